// ===== hw/rtl/imaw_pkg.sv =====
// Shared types and constants for the IMA ADPCM WAV block decoder.
// Holds the command format passed from the byte parser to the decode engine,
// and the standard IMA step and index tables. No dependencies.
package imaw_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_STEREO_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_BLOCK = 2'd2;

  localparam logic [15:0] BLOCK_BYTES_RESET       = 16'd256;
  localparam logic [15:0] SAMPLES_PER_BLOCK_RESET = 16'd505;

  localparam int unsigned STEP_TABLE_ENTRIES = 89;
  localparam int unsigned INDEX_MAX          = STEP_TABLE_ENTRIES - 1;
  localparam int unsigned IDX_W              = 7;

  localparam logic signed [17:0] PRED_MAX = 18'sd32767;
  localparam logic signed [17:0] PRED_MIN = -18'sd32768;

  localparam logic [3:0] NIBBLE_MASK = 4'hF;

  // Work items queued between the parser and the decode engine.
  typedef enum logic [1:0] {
    CMD_PRED,    // load a header predictor and emit it
    CMD_INDEX,   // load a header step index
    CMD_MONO,    // decode one or two nibbles of a mono byte
    CMD_STEREO   // decode a left byte and a right byte as two frames
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic        ch;         // channel for header commands
    logic [15:0] data;       // predictor, index, byte, or {right, left} bytes
    logic [1:0]  last_step;  // number of decode steps minus one
    logic [3:0]  emit;       // steps that produce a result
    logic [3:0]  ends;       // block_end flag per step
    logic [3:0]  lasts;      // run_last flag per step
  } cmd_t;

  localparam logic [14:0] STEP_TABLE [STEP_TABLE_ENTRIES] = '{
    15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
    15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
    15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
    15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
    15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
    15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
    15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
    15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
    15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
    15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623,
    15'd27086, 15'd29794, 15'd32767
  };

  localparam logic signed [7:0] INDEX_ADJUST [8] = '{
    -8'sd1, -8'sd1, -8'sd1, -8'sd1, 8'sd2, 8'sd4, 8'sd6, 8'sd8
  };

endpackage

// ===== hw/rtl/ima_adpcm_wav_block_decoder_unit.sv =====
// Top level of the IMA ADPCM WAV block decoder: byte parser, command queue
// and decode engine. Depends on imaw_pkg, imaw_front, imaw_queue, imaw_back.
//
// Channel   Direction  Handshake               Payload
// cfg       in         cfg_valid / cfg_ready   cfg_index, cfg_data
// data      in         data_valid / data_ready data_byte
// sample    out        sample_valid / sample_ready
//                                              sample, channel, block_end, run_last
//
// The parser takes one data byte per cycle while the command queue has room.
// The decode engine runs one nibble decode per cycle while the sample output
// is not stalled, from the table lookup through the predictor add and saturation;
// a mono byte takes one or two decode steps, a stereo group four right bytes of
// four decode steps each (left bytes are only stored), and a header byte at most one.
// With the engine idle, the first result of a byte passes through a queue entry
// and the registered sample output before it is offered.
// Reset is synchronous and clears configuration, position, frame count,
// predictors and step indexes; there is no clearing pass after reset.
// A stalled sample output holds the engine, and the queue lets the parser
// keep taking bytes until it fills; configuration writes are always accepted.
module ima_adpcm_wav_block_decoder_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [imaw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data,
  input  logic                           data_valid,
  output logic                           data_ready,
  input  logic [7:0]                     data_byte,
  output logic                           sample_valid,
  input  logic                           sample_ready,
  output logic signed [15:0]             sample,
  output logic                           channel,
  output logic                           block_end,
  output logic                           run_last
);
  import imaw_pkg::*;

  // Parser to queue.
  logic cmd_in_valid;
  logic cmd_in_ready;
  cmd_t cmd_in;

  // Queue to decode engine.
  logic cmd_out_valid;
  logic cmd_out_ready;
  cmd_t cmd_out;

  // Registers are writable in any cycle; the user must write them only while idle, the block does not enforce it.
  assign cfg_ready = 1'b1;

  imaw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .data_valid (data_valid),
    .data_ready (data_ready),
    .data_byte  (data_byte),
    .cmd_valid  (cmd_in_valid),
    .cmd_ready  (cmd_in_ready),
    .cmd        (cmd_in)
  );

  imaw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (cmd_in_valid),
    .push_ready (cmd_in_ready),
    .push_data  (cmd_in),
    .pop_valid  (cmd_out_valid),
    .pop_ready  (cmd_out_ready),
    .pop_data   (cmd_out)
  );

  imaw_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_out_valid),
    .cmd_ready    (cmd_out_ready),
    .cmd          (cmd_out),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .channel      (channel),
    .block_end    (block_end),
    .run_last     (run_last)
  );

endmodule

// ===== hw/rtl/imaw_front.sv =====
// Byte parser of the IMA ADPCM WAV block decoder: configuration registers,
// block position, frame count, header and left-byte storage.
// Depends on imaw_pkg; produces imaw_pkg::cmd_t commands for the queue.
module imaw_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic [imaw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [15:0]                       cfg_data,
  input  logic                              data_valid,
  output logic                              data_ready,
  input  logic [7:0]                        data_byte,
  output logic                              cmd_valid,
  input  logic                              cmd_ready,
  output imaw_pkg::cmd_t                    cmd
);
  import imaw_pkg::*;

  logic        stereo_mode;
  logic [15:0] block_bytes;
  logic [15:0] samples_per_block;

  logic [15:0] pos;
  logic [15:0] pos_next;
  logic [15:0] fd;
  logic [15:0] fd_next;
  logic [7:0]  hlb;
  logic [7:0]  left_store [4];

  logic [15:0]       fd_eff;
  logic [15:0]       fd1;
  logic [15:0]       fd2;
  logic              room;
  logic              room2;
  logic              has_cmd;
  logic              hlb_we;
  logic              store_we;
  logic              group_fits;
  logic [15:0]       lep;
  logic [IDX_W-1:0]  hdr_idx;
  logic              accept;

  assign data_ready = cmd_ready;
  assign accept     = data_valid && data_ready;
  assign cmd_valid  = data_valid && has_cmd;

  always_comb begin
    fd_eff     = (pos == 16'd0) ? 16'd0 : fd;
    fd1        = fd_eff + 16'd1;
    fd2        = fd_eff + 16'd2;
    room       = fd_eff < samples_per_block;
    room2      = fd1 < samples_per_block;
    hdr_idx    = (data_byte > 8'(INDEX_MAX)) ? IDX_W'(INDEX_MAX) : data_byte[IDX_W-1:0];
    group_fits = ({1'b0, pos[15:3], 3'b000} + 17'd8) <= {1'b0, block_bytes};

    // Position of the last byte in the block that can produce output.
    if (!stereo_mode) begin
      lep = (block_bytes > 16'd4) ? block_bytes - 16'd1 : 16'd1;
    end else if (block_bytes >= 16'd16) begin
      lep = {block_bytes[15:3], 3'b000} - 16'd1;
    end else begin
      lep = (block_bytes > 16'd5) ? 16'd5 : 16'd1;
    end

    fd_next  = fd_eff;
    cmd      = '0;
    has_cmd  = 1'b0;
    hlb_we   = 1'b0;
    store_we = 1'b0;

    if (!stereo_mode) begin
      if (pos == 16'd0) begin
        hlb_we = 1'b1;
      end else if (pos == 16'd1) begin
        has_cmd      = 1'b1;
        cmd.op       = CMD_PRED;
        cmd.data     = {data_byte, hlb};
        cmd.emit     = 4'b0001;
        cmd.lasts    = 4'b0001;
        cmd.ends[0]  = samples_per_block <= 16'd1;
        fd_next      = 16'd1;
      end else if (pos == 16'd2) begin
        has_cmd  = 1'b1;
        cmd.op   = CMD_INDEX;
        cmd.data = 16'(hdr_idx);
      end else if (pos >= 16'd4 && room) begin
        has_cmd     = 1'b1;
        cmd.op      = CMD_MONO;
        cmd.data    = {8'd0, data_byte};
        cmd.ends[0] = !room2;
        fd_next     = fd1;
        if (room2) begin
          cmd.last_step = 2'd1;
          cmd.emit      = 4'b0011;
          cmd.lasts     = 4'b0010;
          cmd.ends[1]   = fd2 >= samples_per_block;
          fd_next       = fd2;
        end else begin
          cmd.emit  = 4'b0001;
          cmd.lasts = 4'b0001;
        end
      end
    end else if (pos < 16'd8) begin
      // Two four-byte headers: left channel first, then right.
      unique case (pos[1:0])
        2'd0: hlb_we = 1'b1;
        2'd1: begin
          has_cmd     = 1'b1;
          cmd.op      = CMD_PRED;
          cmd.ch      = pos[2];
          cmd.data    = {data_byte, hlb};
          cmd.emit    = 4'b0001;
          cmd.lasts   = 4'b0001;
          cmd.ends[0] = pos[2] && (samples_per_block <= 16'd1);
          if (pos[2]) begin
            fd_next = 16'd1;
          end
        end
        2'd2: begin
          has_cmd  = 1'b1;
          cmd.op   = CMD_INDEX;
          cmd.ch   = pos[2];
          cmd.data = 16'(hdr_idx);
        end
        default: ;
      endcase
    end else if (!pos[2]) begin
      store_we = 1'b1;
    end else if (group_fits && room) begin
      has_cmd       = 1'b1;
      cmd.op        = CMD_STEREO;
      cmd.data      = {data_byte, left_store[pos[1:0]]};
      cmd.last_step = 2'd3;
      cmd.ends[1]   = !room2;
      fd_next       = fd1;
      if (room2) begin
        cmd.emit    = 4'b1111;
        cmd.lasts   = 4'b1000;
        cmd.ends[3] = fd2 >= samples_per_block;
        fd_next     = fd2;
      end else begin
        cmd.emit  = 4'b0011;
        cmd.lasts = 4'b0010;
      end
    end

    if (pos == lep) begin
      cmd.ends = cmd.ends | cmd.lasts;
    end

    pos_next = (({1'b0, pos} + 17'd1) >= {1'b0, block_bytes}) ? 16'd0 : pos + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stereo_mode       <= 1'b0;
      block_bytes       <= BLOCK_BYTES_RESET;
      samples_per_block <= SAMPLES_PER_BLOCK_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_STEREO_MODE:       stereo_mode       <= cfg_data[0];
        REG_BLOCK_BYTES:       block_bytes       <= cfg_data;
        REG_SAMPLES_PER_BLOCK: samples_per_block <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= 16'd0;
      fd  <= 16'd0;
    end else if (accept) begin
      pos <= pos_next;
      fd  <= fd_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hlb_we) begin
      hlb <= data_byte;
    end
    if (accept && store_we) begin
      left_store[pos[1:0]] <= data_byte;
    end
  end

endmodule

// ===== hw/rtl/imaw_queue.sv =====
// Command queue between the byte parser and the decode engine.
// Depends on imaw_pkg for the command type; DEPTH must be at least 2.
module imaw_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  imaw_pkg::cmd_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output imaw_pkg::cmd_t pop_data
);
  import imaw_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("command queue count beyond depth");
`endif

endmodule

// ===== hw/rtl/imaw_back.sv =====
// Decode engine of the IMA ADPCM WAV block decoder: per-channel predictor and
// step index, one nibble decode per cycle while the sample output is not stalled,
// registered result output. Depends on imaw_pkg; takes imaw_pkg::cmd_t commands from the queue.
module imaw_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  imaw_pkg::cmd_t     cmd,
  output logic               sample_valid,
  input  logic               sample_ready,
  output logic signed [15:0] sample,
  output logic               channel,
  output logic               block_end,
  output logic               run_last
);
  import imaw_pkg::*;

  logic signed [15:0] predictor  [2];
  logic [IDX_W-1:0]   step_index [2];
  logic [1:0]         step;

  logic               cur_emit;
  logic               advance;
  logic               dch;
  logic [3:0]         code;
  logic [IDX_W-1:0]   idx;
  logic [14:0]        stp;
  logic [16:0]        diff;
  logic signed [17:0] psum;
  logic signed [15:0] psat;
  logic signed [7:0]  nidx;
  logic [IDX_W-1:0]   nsat;
  logic signed [15:0] result;

  assign cur_emit  = cmd.emit[step];
  assign advance   = cmd_valid && (!cur_emit || !sample_valid || sample_ready);
  assign cmd_ready = advance && (step == cmd.last_step);

  always_comb begin
    // Stereo steps run left low, right low, left high, right high.
    code = 4'd0;
    dch  = cmd.ch;
    unique case (cmd.op)
      CMD_MONO: code = step[0] ? cmd.data[7:4] : cmd.data[3:0];
      CMD_STEREO: begin
        dch = step[0];
        unique case (step)
          2'd0: code = cmd.data[3:0];
          2'd1: code = cmd.data[11:8];
          2'd2: code = cmd.data[7:4];
          2'd3: code = cmd.data[15:12];
          default: code = 4'd0;
        endcase
      end
      default: code = 4'd0;
    endcase
    code = code & NIBBLE_MASK;

    idx  = (step_index[dch] > IDX_W'(INDEX_MAX)) ? IDX_W'(INDEX_MAX) : step_index[dch];
    stp  = STEP_TABLE[idx];
    diff = 17'(stp >> 3)
         + (code[0] ? 17'(stp >> 2) : 17'd0)
         + (code[1] ? 17'(stp >> 1) : 17'd0)
         + (code[2] ? 17'(stp) : 17'd0);
    psum = code[3] ? 18'(predictor[dch]) - $signed({1'b0, diff})
                   : 18'(predictor[dch]) + $signed({1'b0, diff});
    if (psum > PRED_MAX) begin
      psat = 16'(PRED_MAX);
    end else if (psum < PRED_MIN) begin
      psat = 16'(PRED_MIN);
    end else begin
      psat = psum[15:0];
    end

    nidx = $signed({1'b0, idx}) + INDEX_ADJUST[code[2:0]];
    if (nidx < 8'sd0) begin
      nsat = '0;
    end else if (nidx > 8'(INDEX_MAX)) begin
      nsat = IDX_W'(INDEX_MAX);
    end else begin
      nsat = nidx[IDX_W-1:0];
    end

    result = (cmd.op == CMD_PRED) ? $signed(cmd.data) : psat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      predictor[0]  <= '0;
      predictor[1]  <= '0;
      step_index[0] <= '0;
      step_index[1] <= '0;
      step          <= '0;
    end else if (advance) begin
      step <= cmd_ready ? 2'd0 : step + 2'd1;
      unique case (cmd.op)
        CMD_PRED:  predictor[dch]  <= $signed(cmd.data);
        CMD_INDEX: step_index[dch] <= cmd.data[IDX_W-1:0];
        CMD_MONO, CMD_STEREO: begin
          predictor[dch]  <= psat;
          step_index[dch] <= nsat;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (advance && cur_emit) begin
      sample_valid <= 1'b1;
    end else if (sample_ready) begin
      sample_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && cur_emit) begin
      sample    <= result;
      channel   <= dch;
      block_end <= cmd.ends[step];
      run_last  <= cmd.lasts[step];
    end
  end

`ifndef SYNTHESIS
  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |-> step <= cmd.last_step)
    else $error("decode step beyond command length");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    step_index[0] <= IDX_W'(INDEX_MAX) && step_index[1] <= IDX_W'(INDEX_MAX))
    else $error("step index beyond table");

  // Steps after the run_last result may still decode, but never emit.
  a_emit_on_last: assert property (@(posedge clk) disable iff (rst)
    (advance && cur_emit && cmd.lasts[step]) |-> ((cmd.emit >> step) == 4'b0001))
    else $error("run_last result followed by further results of the command");
`endif

endmodule
